@@ rtl/pjs_pkg.sv @@
// Shared types and constants for the packet sequence and jitter statistics block.
// Holds the transaction payload structs, the sequencer states and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package pjs_pkg;

   localparam int SEQ_W = 32;
   localparam int TIME_W = 48;
   localparam int CNT_W = 32;
   localparam int TOTAL_W = 48;
   localparam int LOSS_W = 15;
   localparam int AVG_W = 40;
   localparam int ALU_W = 50;
   localparam int REM_W = 33;
   localparam int MUL_W = 39;
   localparam int LOSS_Q_EXTRA = 8;
   localparam int ITER_W = $clog2(AVG_W);

   typedef struct packed {
      logic              operation;
      logic [SEQ_W-1:0]  sequence_req;
      logic [TIME_W-1:0] send_time;
      logic [TIME_W-1:0] recv_time;
   } pjs_req_type;

   typedef struct packed {
      logic signed [SEQ_W-1:0] seq_gap;
      logic                    stats_valid;
      logic [LOSS_W-1:0]       loss_rate_pct;
      logic [AVG_W-1:0]        avg_jitter;
      logic [CNT_W-1:0]        peak_jitter;
      logic [CNT_W-1:0]        received_count;
      logic [CNT_W-1:0]        lost_count;
      logic [CNT_W-1:0]        reorder_count;
   } pjs_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_GAP,
      ST_DEC,
      ST_LOSS,
      ST_JA,
      ST_JB,
      ST_JDIFF,
      ST_JNEG,
      ST_JSUM,
      ST_JPEAK,
      ST_ARR_DONE,
      ST_SNAP,
      ST_TOT,
      ST_MUL_A,
      ST_MUL_B,
      ST_LDIV,
      ST_AVG_CHK,
      ST_ADIV,
      ST_SNAP_DONE
   } pjs_state_type;

   typedef struct packed {
      logic start;
      logic snap;
      logic first;
      logic alu_neg;
      logic gap_stop;
      logic jitter_ok;
      logic empty;
      logic total_zero;
      logic samples_zero;
      logic out_free;
   } pjs_status_type;

   typedef struct packed {
      pjs_state_type state;
      logic          div_last;
   } pjs_ctrl_type;

endpackage

@@ rtl/pjs_alu.sv @@
// Shared adder and subtractor used by every arithmetic step of the sequencer.
// Depends on pjs_pkg for the datapath width.
`timescale 1ns / 1ps

module pjs_alu
   import pjs_pkg::*;
(
   input  logic [ALU_W-1:0] op_a,
   input  logic [ALU_W-1:0] op_b,
   input  logic             sub,
   output logic [ALU_W-1:0] sum
);

   logic [ALU_W-1:0] b_sel;

   assign b_sel = sub ? ~op_b : op_b;
   assign sum = op_a + b_sel + ALU_W'(sub);

endmodule

@@ rtl/pjs_ctrl.sv @@
// Sequencer for the statistics block: state register and division step counter.
// Depends on pjs_pkg for the state enum and the status and control structs.
`timescale 1ns / 1ps

module pjs_ctrl
   import pjs_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  pjs_status_type status,
   output pjs_ctrl_type   ctrl
);

   localparam logic [ITER_W-1:0] LOSS_LAST = ITER_W'(FRACTION_BITS + LOSS_Q_EXTRA - 1);
   localparam logic [ITER_W-1:0] AVG_LAST = ITER_W'(AVG_W - 1);

   pjs_state_type     state_ff;
   pjs_state_type     state_in;
   logic [ITER_W-1:0] iter_ff;
   logic [ITER_W-1:0] iter_in;
   logic              div_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      div_last = ((state_ff == ST_LDIV) && (iter_ff == LOSS_LAST)) ||
                 ((state_ff == ST_ADIV) && (iter_ff == AVG_LAST));
      if (((state_ff == ST_LDIV) || (state_ff == ST_ADIV)) && !div_last) begin
         iter_in = iter_ff + 1'b1;
      end else begin
         iter_in = '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (status.start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.snap) begin
               state_in = ST_SNAP;
            end else if (status.first) begin
               state_in = ST_ARR_DONE;
            end else begin
               state_in = ST_GAP;
            end
         end
         ST_GAP: state_in = status.gap_stop ? ST_ARR_DONE : ST_DEC;
         ST_DEC: state_in = ST_LOSS;
         ST_LOSS: state_in = status.jitter_ok ? ST_JA : ST_ARR_DONE;
         ST_JA: state_in = ST_JB;
         ST_JB: state_in = ST_JDIFF;
         ST_JDIFF: state_in = status.alu_neg ? ST_JNEG : ST_JSUM;
         ST_JNEG: state_in = ST_JSUM;
         ST_JSUM: state_in = ST_JPEAK;
         ST_JPEAK: state_in = ST_ARR_DONE;
         ST_ARR_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SNAP: state_in = status.empty ? ST_SNAP_DONE : ST_TOT;
         ST_TOT: state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = status.total_zero ? ST_AVG_CHK : ST_LDIV;
         ST_LDIV: begin
            if (div_last) begin
               state_in = ST_AVG_CHK;
            end
         end
         ST_AVG_CHK: begin
            if (status.samples_zero || !status.alu_neg) begin
               state_in = ST_SNAP_DONE;
            end else begin
               state_in = ST_ADIV;
            end
         end
         ST_ADIV: begin
            if (div_last) begin
               state_in = ST_SNAP_DONE;
            end
         end
         ST_SNAP_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ctrl.state = state_ff;
   assign ctrl.div_last = div_last;

endmodule

@@ rtl/packet_sequence_jitter_stats.sv @@
// Top level of the per-stream packet sequence, loss and jitter statistics block.
// Depends on pjs_pkg, pjs_alu and pjs_ctrl.
//
// Usage: the req channel carries one transaction per packet arrival (operation 0) or
// per snapshot request (operation 1). Each request gives exactly one transaction on
// the rsp channel. Both channels use valid and stall; a transaction moves on a clock
// edge with valid high and stall low.
// The block takes one request at a time and holds req_stall high while it works.
// The arithmetic steps run on one shared 50-bit adder under a small sequencer.
// A snapshot result waits on the two bit-serial restoring divisions, which produce
// one quotient bit per cycle on the shared adder. The next request is accepted in
// the cycle after a result is registered.
// The result sits in an output register, so the next request is taken while a
// result waits. If rsp_stall stays high, a finished item waits for the output
// register before it commits and frees the input.
// Synchronous reset clears all counters and the output valid, and marks the next
// arrival as the first, which is counted as received but only seeds the stream
// state. req_stall is high during reset.
`timescale 1ns / 1ps

module packet_sequence_jitter_stats
   import pjs_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pjs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pjs_rsp_type rsp_data
);

   localparam int AVG_NUM_W = TOTAL_W + FRACTION_BITS;
   localparam int AVG_HI_W = AVG_NUM_W - AVG_W;

   pjs_ctrl_type   ctrl;
   pjs_status_type status;

   logic [ALU_W-1:0] alu_a;
   logic [ALU_W-1:0] alu_b;
   logic             alu_sub;
   logic [ALU_W-1:0] alu_sum;

   pjs_req_type       req_ff;
   pjs_req_type       req_in;
   logic              awaiting_ff;
   logic              awaiting_in;
   logic [SEQ_W-1:0]  highest_ff;
   logic [SEQ_W-1:0]  highest_in;
   logic [TIME_W-1:0] prev_send_ff;
   logic [TIME_W-1:0] prev_send_in;
   logic [TIME_W-1:0] prev_arr_ff;
   logic [TIME_W-1:0] prev_arr_in;
   logic [CNT_W-1:0]  rx_ff;
   logic [CNT_W-1:0]  rx_in;
   logic [CNT_W-1:0]  lost_ff;
   logic [CNT_W-1:0]  lost_in;
   logic [CNT_W-1:0]  late_ff;
   logic [CNT_W-1:0]  late_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [CNT_W-1:0]  peak_ff;
   logic [CNT_W-1:0]  peak_in;
   logic [CNT_W-1:0]  samples_ff;
   logic [CNT_W-1:0]  samples_in;
   logic [SEQ_W-1:0]  gap_ff;
   logic [SEQ_W-1:0]  gap_in;
   logic [ALU_W-1:0]  aux_ff;
   logic [ALU_W-1:0]  aux_in;
   logic [ALU_W-1:0]  acc_ff;
   logic [ALU_W-1:0]  acc_in;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   logic [AVG_W-1:0]  quo_ff;
   logic [AVG_W-1:0]  quo_in;
   logic [LOSS_W-1:0] loss_ff;
   logic [LOSS_W-1:0] loss_in;
   logic [AVG_W-1:0]  avg_ff;
   logic [AVG_W-1:0]  avg_in;
   pjs_rsp_type       rsp_ff;
   pjs_rsp_type       rsp_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic                 accept;
   logic [CNT_W-1:0]     mag32;
   logic [REM_W:0]       div_shift;
   logic [REM_W-1:0]     divisor;
   logic                 q_bit;
   logic [AVG_W-1:0]     quo_next;
   logic [AVG_NUM_W-1:0] avg_num;
   logic [AVG_HI_W-1:0]  avg_hi;
   logic [MUL_W-1:0]     prod;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   pjs_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .ctrl  (ctrl)
   );

   pjs_alu u_alu (
      .op_a(alu_a),
      .op_b(alu_b),
      .sub (alu_sub),
      .sum (alu_sum)
   );

   assign req_stall = reset || (ctrl.state != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign mag32 = (|aux_ff[ALU_W-1:CNT_W]) ? '1 : aux_ff[CNT_W-1:0];
   assign div_shift = {rem_ff, quo_ff[AVG_W-1]};
   assign divisor = (ctrl.state == ST_LDIV) ? acc_ff[REM_W-1:0] : REM_W'(samples_ff);
   assign q_bit = !alu_sum[ALU_W-1];
   assign quo_next = {quo_ff[AVG_W-2:0], q_bit};
   assign avg_num = AVG_NUM_W'(total_ff) << FRACTION_BITS;
   assign avg_hi = avg_num[AVG_NUM_W-1:AVG_W];
   assign prod = alu_sum[MUL_W-1:0];

   assign status.start = req_valid;
   assign status.snap = req_ff.operation;
   assign status.first = awaiting_ff;
   assign status.alu_neg = alu_sum[ALU_W-1];
   assign status.gap_stop = alu_sum[SEQ_W-1] || (alu_sum[SEQ_W-1:0] == '0);
   assign status.jitter_ok = (prev_send_ff != '0) && (req_ff.send_time != '0);
   assign status.empty = (rx_ff == '0) && (lost_ff == '0) && (late_ff == '0);
   assign status.total_zero = (acc_ff[REM_W-1:0] == '0);
   assign status.samples_zero = (samples_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Operand selection for the shared adder.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      alu_sub = 1'b0;
      unique case (ctrl.state) inside
         ST_GAP: begin
            alu_a = ALU_W'(req_ff.sequence_req);
            alu_b = ALU_W'(highest_ff);
            alu_sub = 1'b1;
         end
         ST_DEC: begin
            alu_a = ALU_W'(gap_ff);
            alu_b = '1;
         end
         ST_LOSS: begin
            alu_a = ALU_W'(lost_ff);
            alu_b = aux_ff;
         end
         ST_JA: begin
            alu_a = ALU_W'(req_ff.recv_time);
            alu_b = ALU_W'(prev_send_ff);
         end
         ST_JB: begin
            alu_a = ALU_W'(prev_arr_ff);
            alu_b = ALU_W'(req_ff.send_time);
         end
         ST_JDIFF: begin
            alu_a = aux_ff;
            alu_b = acc_ff;
            alu_sub = 1'b1;
         end
         ST_JNEG: begin
            alu_a = acc_ff;
            alu_b = aux_ff;
            alu_sub = 1'b1;
         end
         ST_JSUM: begin
            alu_a = ALU_W'(total_ff);
            alu_b = aux_ff;
         end
         ST_JPEAK: begin
            alu_a = ALU_W'(peak_ff);
            alu_b = ALU_W'(mag32);
            alu_sub = 1'b1;
         end
         ST_TOT: begin
            alu_a = ALU_W'(rx_ff);
            alu_b = ALU_W'(lost_ff);
         end
         // Times one hundred is built as 64 + 32 + 4 over two steps.
         ST_MUL_A: begin
            alu_a = ALU_W'({lost_ff, 6'b0});
            alu_b = ALU_W'({lost_ff, 5'b0});
         end
         ST_MUL_B: begin
            alu_a = aux_ff;
            alu_b = ALU_W'({lost_ff, 2'b0});
         end
         ST_LDIV, ST_ADIV: begin
            alu_a = ALU_W'(div_shift);
            alu_b = ALU_W'(divisor);
            alu_sub = 1'b1;
         end
         ST_AVG_CHK: begin
            alu_a = ALU_W'(avg_hi);
            alu_b = ALU_W'(samples_ff);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath and statistics updates.
   always_comb begin
      req_in = req_ff;
      awaiting_in = awaiting_ff;
      highest_in = highest_ff;
      prev_send_in = prev_send_ff;
      prev_arr_in = prev_arr_ff;
      rx_in = rx_ff;
      lost_in = lost_ff;
      late_in = late_ff;
      total_in = total_ff;
      peak_in = peak_ff;
      samples_in = samples_ff;
      gap_in = gap_ff;
      aux_in = aux_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      loss_in = loss_ff;
      avg_in = avg_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         req_in = req_data;
      end

      unique case (ctrl.state) inside
         ST_GAP: gap_in = alu_sum[SEQ_W-1:0];
         ST_DEC: aux_in = alu_sum;
         ST_LOSS: begin
            lost_in = (|alu_sum[ALU_W-1:CNT_W]) ? '1 : alu_sum[CNT_W-1:0];
            highest_in = req_ff.sequence_req;
         end
         ST_JA: aux_in = alu_sum;
         ST_JB: acc_in = alu_sum;
         ST_JDIFF: begin
            if (!alu_sum[ALU_W-1]) begin
               aux_in = alu_sum;
            end
         end
         ST_JNEG: aux_in = alu_sum;
         ST_JSUM: begin
            if (alu_sum >= ALU_W'({TOTAL_W{1'b1}})) begin
               total_in = '1;
            end else begin
               total_in = alu_sum[TOTAL_W-1:0];
            end
         end
         ST_JPEAK: begin
            if (alu_sum[ALU_W-1]) begin
               peak_in = mag32;
            end
            samples_in = sat_inc(samples_ff);
         end
         ST_ARR_DONE: begin
            if (status.out_free) begin
               rx_in = sat_inc(rx_ff);
               if (awaiting_ff) begin
                  awaiting_in = 1'b0;
                  highest_in = req_ff.sequence_req;
               end else if (gap_ff[SEQ_W-1]) begin
                  late_in = sat_inc(late_ff);
               end
               prev_send_in = req_ff.send_time;
               prev_arr_in = req_ff.recv_time;
               rsp_in = '0;
               rsp_in.seq_gap = awaiting_ff ? '0 : $signed(gap_ff);
               rsp_valid_in = 1'b1;
            end
         end
         ST_TOT: acc_in = alu_sum;
         ST_MUL_A: aux_in = alu_sum;
         ST_MUL_B: begin
            loss_in = '0;
            rem_in = REM_W'(prod[MUL_W-1:LOSS_Q_EXTRA]);
            quo_in = {prod[LOSS_Q_EXTRA-1:0], (AVG_W - LOSS_Q_EXTRA)'(0)};
         end
         ST_LDIV, ST_ADIV: begin
            rem_in = q_bit ? alu_sum[REM_W-1:0] : div_shift[REM_W-1:0];
            quo_in = quo_next;
            if (ctrl.div_last) begin
               if (ctrl.state == ST_LDIV) begin
                  loss_in = (|quo_next[AVG_W-1:LOSS_W]) ? '1 : quo_next[LOSS_W-1:0];
               end else begin
                  avg_in = quo_next;
               end
            end
         end
         ST_AVG_CHK: begin
            if (status.samples_zero) begin
               avg_in = '0;
            end else if (!alu_sum[ALU_W-1]) begin
               avg_in = '1;
            end else begin
               rem_in = REM_W'(avg_hi);
               quo_in = avg_num[AVG_W-1:0];
            end
         end
         ST_SNAP_DONE: begin
            if (status.out_free) begin
               rsp_in = '0;
               rsp_valid_in = 1'b1;
               if (!status.empty) begin
                  rsp_in.stats_valid = 1'b1;
                  rsp_in.loss_rate_pct = loss_ff;
                  rsp_in.avg_jitter = avg_ff;
                  rsp_in.peak_jitter = peak_ff;
                  rsp_in.received_count = rx_ff;
                  rsp_in.lost_count = lost_ff;
                  rsp_in.reorder_count = late_ff;
                  rx_in = '0;
                  lost_in = '0;
                  late_in = '0;
                  total_in = '0;
                  peak_in = '0;
                  samples_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
         highest_ff <= '0;
         prev_send_ff <= '0;
         prev_arr_ff <= '0;
         rx_ff <= '0;
         lost_ff <= '0;
         late_ff <= '0;
         total_ff <= '0;
         peak_ff <= '0;
         samples_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         awaiting_ff <= awaiting_in;
         highest_ff <= highest_in;
         prev_send_ff <= prev_send_in;
         prev_arr_ff <= prev_arr_in;
         rx_ff <= rx_in;
         lost_ff <= lost_in;
         late_ff <= late_in;
         total_ff <= total_in;
         peak_ff <= peak_in;
         samples_ff <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      gap_ff <= gap_in;
      aux_ff <= aux_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      loss_ff <= loss_in;
      avg_ff <= avg_in;
      rsp_ff <= rsp_in;
   end

endmodule

@@ dv/packet_sequence_jitter_stats_test.sv @@
// Self-checking testbench for packet_sequence_jitter_stats: directed and random traffic
// against a cycle-free predictor of the per-stream loss, reorder and jitter statistics.
// Depends on pjs_pkg and the packet_sequence_jitter_stats RTL.
`timescale 1ns / 1ps

module packet_sequence_jitter_stats_test;
   import pjs_pkg::*;

   localparam int FRACTION_BITS = 8;
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_SNAPSHOT = 1'b1;
   localparam logic [TOTAL_W-1:0] JITTER_SUM_MAX = '1;
   localparam logic [LOSS_W-1:0] LOSS_MAX = '1;
   localparam logic [AVG_W-1:0] AVG_MAX = '1;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 125;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pjs_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pjs_rsp_type rsp_data;

   pjs_req_type pending_items[$];
   pjs_rsp_type expected_reports[$];
   logic req_taken = 1'b0;
   int issued_total = 0;
   int accepted_total = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int holdoff_requests = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;

   logic               first_pending = 1'b1;
   logic [SEQ_W-1:0]   top_seq = '0;
   logic [TIME_W-1:0]  last_send = '0;
   logic [TIME_W-1:0]  last_arrival = '0;
   logic [CNT_W-1:0]   period_rx = '0;
   logic [CNT_W-1:0]   period_lost = '0;
   logic [CNT_W-1:0]   period_reordered = '0;
   logic [TOTAL_W-1:0] jitter_sum = '0;
   logic [CNT_W-1:0]   jitter_max = '0;
   logic [CNT_W-1:0]   jitter_count = '0;

   logic [SEQ_W-1:0]   stream_seq = '1;
   logic [TIME_W-1:0]  stream_send = 48'hFFFF_FFFF_F000;
   logic [TIME_W-1:0]  stream_arrival = 48'h0000_0000_1000;

   packet_sequence_jitter_stats #(
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [CNT_W-1:0] bump_saturated(logic [CNT_W-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   function automatic pjs_rsp_type stream_stats_update(pjs_req_type item);
      pjs_rsp_type report;
      logic [SEQ_W-1:0] gap;
      logic [CNT_W:0] lost_sum;
      logic [TIME_W+1:0] lead;
      logic [TIME_W+1:0] lag;
      logic [TIME_W+1:0] swing;
      logic [CNT_W-1:0] swing_clipped;
      logic [CNT_W:0] denom;
      logic [63:0] loss_q;
      logic [63:0] avg_q;
      report = '0;
      if (item.operation == OP_ARRIVAL) begin
         period_rx = bump_saturated(period_rx);
         if (first_pending) begin
            first_pending = 1'b0;
            top_seq = item.sequence_req;
         end else begin
            gap = item.sequence_req - top_seq;
            report.seq_gap = gap;
            if (gap[SEQ_W-1]) begin
               period_reordered = bump_saturated(period_reordered);
            end else if (gap != 0) begin
               lost_sum = {1'b0, period_lost} + {1'b0, gap} - 1'b1;
               period_lost = lost_sum[CNT_W] ? '1 : lost_sum[CNT_W-1:0];
               top_seq = item.sequence_req;
               if (last_send != 0 && item.send_time != 0) begin
                  lead = {2'b00, item.recv_time} + {2'b00, last_send};
                  lag = {2'b00, last_arrival} + {2'b00, item.send_time};
                  swing = (lead >= lag) ? lead - lag : lag - lead;
                  if (swing >= {2'b00, JITTER_SUM_MAX - jitter_sum}) begin
                     jitter_sum = JITTER_SUM_MAX;
                  end else begin
                     jitter_sum = jitter_sum + swing[TOTAL_W-1:0];
                  end
                  swing_clipped = (swing > {18'b0, {CNT_W{1'b1}}}) ? '1 : swing[CNT_W-1:0];
                  if (swing_clipped > jitter_max) begin
                     jitter_max = swing_clipped;
                  end
                  jitter_count = bump_saturated(jitter_count);
               end
            end
         end
         last_send = item.send_time;
         last_arrival = item.recv_time;
      end else begin
         denom = {1'b0, period_rx} + {1'b0, period_lost};
         if (denom != 0 || period_reordered != 0) begin
            loss_q = 0;
            avg_q = 0;
            if (denom != 0) begin
               loss_q = (({32'b0, period_lost} * 64'd100) << FRACTION_BITS) / {31'b0, denom};
            end
            if (jitter_count != 0) begin
               avg_q = ({16'b0, jitter_sum} << FRACTION_BITS) / {32'b0, jitter_count};
            end
            report.stats_valid = 1'b1;
            report.loss_rate_pct = (loss_q > {49'b0, LOSS_MAX}) ? LOSS_MAX : loss_q[LOSS_W-1:0];
            report.avg_jitter = (avg_q > {24'b0, AVG_MAX}) ? AVG_MAX : avg_q[AVG_W-1:0];
            report.peak_jitter = jitter_max;
            report.received_count = period_rx;
            report.lost_count = period_lost;
            report.reorder_count = period_reordered;
            period_rx = '0;
            period_lost = '0;
            period_reordered = '0;
            jitter_sum = '0;
            jitter_max = '0;
            jitter_count = '0;
         end
      end
      return report;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic check_report(pjs_rsp_type got, pjs_rsp_type want);
      if (got.seq_gap !== want.seq_gap)
         report_mismatch("seq_gap", 64'(got.seq_gap), 64'(want.seq_gap));
      if (got.stats_valid !== want.stats_valid)
         report_mismatch("stats_valid", 64'(got.stats_valid), 64'(want.stats_valid));
      if (got.loss_rate_pct !== want.loss_rate_pct)
         report_mismatch("loss_rate_pct", 64'(got.loss_rate_pct), 64'(want.loss_rate_pct));
      if (got.avg_jitter !== want.avg_jitter)
         report_mismatch("avg_jitter", 64'(got.avg_jitter), 64'(want.avg_jitter));
      if (got.peak_jitter !== want.peak_jitter)
         report_mismatch("peak_jitter", 64'(got.peak_jitter), 64'(want.peak_jitter));
      if (got.received_count !== want.received_count)
         report_mismatch("received_count", 64'(got.received_count),
                         64'(want.received_count));
      if (got.lost_count !== want.lost_count)
         report_mismatch("lost_count", 64'(got.lost_count), 64'(want.lost_count));
      if (got.reorder_count !== want.reorder_count)
         report_mismatch("reorder_count", 64'(got.reorder_count), 64'(want.reorder_count));
   endtask

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_reports.insert(expected_reports.size(), stream_stats_update(req_data));
            accepted_total++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected transaction, seq_gap", 64'(rsp_data.seq_gap),
                               64'd0);
            end else begin
               check_report(rsp_data, expected_reports.pop_front());
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_seen != holdoff_requests) begin
         rsp_stall <= 1'b1;
         holdoff_seen <= holdoff_requests;
         holdoff_left <= HOLDOFF_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   task automatic queue_item(pjs_req_type item);
      pending_items.insert(pending_items.size(), item);
      issued_total++;
   endtask

   task automatic queue_packet(logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] snd,
                               logic [TIME_W-1:0] arr);
      pjs_req_type item;
      item.operation = OP_ARRIVAL;
      item.sequence_req = seq;
      item.send_time = snd;
      item.recv_time = arr;
      queue_item(item);
   endtask

   task automatic queue_snapshot();
      pjs_req_type item;
      item.operation = OP_SNAPSHOT;
      item.sequence_req = $urandom;
      item.send_time = TIME_W'({$urandom, $urandom});
      item.recv_time = TIME_W'({$urandom, $urandom});
      queue_item(item);
   endtask

   // Mostly an in-order stream with losses, reordering, duplicates and some snapshots; a few fully
   // random packets land anywhere, and the stream follows them when they move forward.
   task automatic queue_stream_traffic(int count);
      int pick;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] step;
      logic [TIME_W-1:0] snd;
      logic [TIME_W-1:0] arr;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99, 0);
         stream_send = stream_send + $urandom_range(25, 15);
         stream_arrival = stream_arrival + $urandom_range(40, 15);
         snd = ($urandom_range(99, 0) < 4) ? '0 : stream_send;
         arr = stream_arrival;
         seq = stream_seq + 1'b1;
         if (pick < 5) begin
            queue_snapshot();
            continue;
         end else if (pick < 10) begin
            seq = $urandom;
            snd = TIME_W'({$urandom, $urandom});
            arr = TIME_W'({$urandom, $urandom});
         end else if (pick < 15) begin
            seq = stream_seq - $urandom_range(40, 1);
         end else if (pick < 19) begin
            seq = stream_seq;
         end else if (pick < 30) begin
            seq = stream_seq + $urandom_range(60, 2);
         end
         step = seq - stream_seq;
         if (!step[SEQ_W-1]) begin
            stream_seq = seq;
         end
         queue_packet(seq, snd, arr);
      end
   endtask

   task automatic run_phase(int sender_idle, int receiver_stall, int count);
      send_idle_pct = sender_idle;
      stall_pct = receiver_stall;
      queue_stream_traffic(count);
      while (accepted_total != issued_total) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_snapshot();
      queue_packet(32'hFFFF_FFFE, 48'd1000, 48'd5000);
      queue_packet(32'hFFFF_FFFE, 48'd1020, 48'd5020);
      queue_packet(32'hFFFF_FFFF, 48'd1040, 48'd5045);
      queue_packet(32'h0000_0002, 48'd1060, 48'd5061);
      queue_packet(32'h0000_0000, 48'd1080, 48'd5070);
      queue_packet(32'h0000_0003, 48'd0, 48'd5090);
      queue_packet(32'h0000_0004, 48'd1100, 48'd5100);
      queue_snapshot();
      queue_snapshot();
      queue_packet(32'h0000_0005, 48'hFFFF_FFFF_FFFF, 48'd0);
      queue_packet(32'h0000_0006, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      queue_snapshot();
      queue_packet(32'h8000_0005, 48'd2000, 48'd6000);
      queue_packet(32'h0000_0004, 48'd2020, 48'd6030);
      queue_packet(32'h8000_0003, 48'd0, 48'd6050);
      queue_packet(32'h0000_0003, 48'd2060, 48'd6070);
      queue_snapshot();
      queue_packet(32'hFFFF_FFFF, 48'd2100, 48'd6100);
      queue_packet(32'h0000_0000, 48'd2120, 48'd6115);
      queue_snapshot();
      while (accepted_total != issued_total) @(posedge clock);

      holdoff_requests++;
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(81, 0, PHASE_ITEMS);
      run_phase(0, 81, PHASE_ITEMS);
      run_phase(11, 11, PHASE_ITEMS);

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("packet_sequence_jitter_stats_test passed");
      end else begin
         $display("packet_sequence_jitter_stats_test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("packet_sequence_jitter_stats_test failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/pjs_pkg.sv
rtl/pjs_alu.sv
rtl/pjs_ctrl.sv
rtl/packet_sequence_jitter_stats.sv
dv/packet_sequence_jitter_stats_test.sv
